@@ rtl/core/fpie_pkg.sv @@
// Shared types and constants for the floating-point integer power unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package fpie_pkg;

  // Controller states, one-hot coded.
  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_SCAN  = 12'b0000_0000_0010,
    ST_NEXT  = 12'b0000_0000_0100,
    ST_MSTART = 12'b0000_0000_1000,
    ST_MPP   = 12'b0000_0001_0000,
    ST_NORM  = 12'b0000_0010_0000,
    ST_ROUND = 12'b0000_0100_0000,
    ST_FINAL = 12'b0000_1000_0000,
    ST_DNORM = 12'b0001_0000_0000,
    ST_DIV   = 12'b0010_0000_0000,
    ST_DPACK = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_e;

  // Result status codes.
  localparam logic [1:0] STAT_NORMAL    = 2'd0;
  localparam logic [1:0] STAT_ZERO_ZERO = 2'd1;
  localparam logic [1:0] STAT_ZERO_NEG  = 2'd2;

  // Double-precision bit patterns.
  localparam logic [63:0] FP_ONE       = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] FP_ZERO_NEG  = 64'h41DF_FFFF_FFC0_0000;
  localparam logic [63:0] FP_DEF_NAN   = 64'hFFF8_0000_0000_0000;
  localparam logic [10:0] FP_EXP_MAX   = 11'h7FF;
  localparam logic [63:0] FP_QUIET_BIT = 64'h0008_0000_0000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic idx_dec;
    logic mstart;
    logic op_mulx;
    logic pp_step;
    logic norm_step;
    logic round;
    logic final_fix;
    logic dnorm_step;
    logic div_step;
    logic dpack;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;
    logic cur_bit;
    logic idx_zero;
    logic mul_spec;
    logic pp_done;
    logic norm_done;
    logic need_div;
    logic d_normed;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/fpie_dp.sv @@
// Datapath of the integer power unit: operand registers, shared split multiplier,
// normalizer, rounder and restoring reciprocal divider. Depends on fpie_pkg.
`default_nettype none

module fpie_dp (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  fpie_pkg::cmd_t   cmd_i,
  output fpie_pkg::sts_t   sts_o,
  input  wire  [63:0]      base_bits_i,
  input  wire signed [31:0] power_value_i,
  output logic [63:0]      result_bits_o,
  output logic [1:0]       status_o
);

  logic [63:0]  base_q, acc_q, res_q;
  logic [31:0]  mag_q;
  logic         neg_q;
  logic [1:0]   stat_q, ostat_q;
  logic [4:0]   idx_q;
  logic [52:0]  ma_q, mb_q;
  logic [2:0]   pcnt_q;
  logic [53:0]  pp_q;
  logic [105:0] p_q;
  logic signed [13:0] er_q, de_q;
  logic         sgn_q;
  logic [52:0]  d_q;
  logic [54:0]  rem_q;
  logic [55:0]  q_q;
  logic [5:0]   dcnt_q;

  // Input classification at load time.
  logic [31:0] pw_u, mag_in;
  logic        in_neg, in_bzero;
  assign pw_u     = power_value_i;
  assign in_neg   = power_value_i[31];
  assign mag_in   = in_neg ? (32'd0 - pw_u) : pw_u;
  assign in_bzero = (base_bits_i[62:0] == 63'd0);

  // Operand fields: the accumulator is always the first operand.
  logic [63:0] opb;
  logic [10:0] a_exp, b_exp;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  assign opb    = cmd_i.op_mulx ? base_q : acc_q;
  assign a_exp  = acc_q[62:52];
  assign b_exp  = opb[62:52];
  assign a_nan  = (a_exp == fpie_pkg::FP_EXP_MAX) && (acc_q[51:0] != 52'd0);
  assign b_nan  = (b_exp == fpie_pkg::FP_EXP_MAX) && (opb[51:0] != 52'd0);
  assign a_inf  = (a_exp == fpie_pkg::FP_EXP_MAX) && (acc_q[51:0] == 52'd0);
  assign b_inf  = (b_exp == fpie_pkg::FP_EXP_MAX) && (opb[51:0] == 52'd0);
  assign a_zero = (acc_q[62:0] == 63'd0);
  assign b_zero = (opb[62:0] == 63'd0);

  // Special-operand product, taken when either operand is NaN, infinite or zero.
  logic        mul_spec;
  logic [63:0] spec_res;
  always_comb begin
    mul_spec = a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    if (a_nan) begin
      spec_res = acc_q | fpie_pkg::FP_QUIET_BIT;
    end else if (b_nan) begin
      spec_res = opb | fpie_pkg::FP_QUIET_BIT;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      spec_res = fpie_pkg::FP_DEF_NAN;
    end else if (a_inf || b_inf) begin
      spec_res = {acc_q[63] ^ opb[63], fpie_pkg::FP_EXP_MAX, 52'd0};
    end else begin
      spec_res = {acc_q[63] ^ opb[63], 63'd0};
    end
  end

  // Unpacked significands and biased exponents (subnormals use exponent one).
  logic [10:0] ea, eb;
  assign ea = (a_exp == 11'd0) ? 11'd1 : a_exp;
  assign eb = (b_exp == 11'd0) ? 11'd1 : b_exp;

  // One 27x27 partial product per cycle; each is registered and added to the sum in the following cycle.
  logic [26:0]  mx, my;
  logic [53:0]  prod;
  logic [5:0]   pp_sh;
  logic [105:0] pp_ext;
  always_comb begin
    case (pcnt_q[1:0])
      2'd0: begin
        mx = ma_q[26:0];
        my = mb_q[26:0];
      end
      2'd1: begin
        mx = ma_q[26:0];
        my = {1'b0, mb_q[52:27]};
      end
      2'd2: begin
        mx = {1'b0, ma_q[52:27]};
        my = mb_q[26:0];
      end
      default: begin
        mx = {1'b0, ma_q[52:27]};
        my = {1'b0, mb_q[52:27]};
      end
    endcase
    case (pcnt_q)
      3'd1:    pp_sh = 6'd0;
      3'd4:    pp_sh = 6'd54;
      default: pp_sh = 6'd27;
    endcase
  end
  assign prod   = mx * my;
  assign pp_ext = {52'd0, pp_q} << pp_sh;

  // Round to nearest-even and pack, with gradual underflow and overflow to infinity.
  logic [6:0]   rsh;
  logic signed [13:0] one_minus_er;
  logic [105:0] t_sh, lost_mask;
  logic [52:0]  rm;
  logic         rg, rst_bit, rinc;
  logic [53:0]  mr;
  logic [12:0]  ef;
  logic [65:0]  mag66;
  logic [63:0]  rnd_bits;
  always_comb begin
    one_minus_er = 14'sd1 - er_q;
    if (er_q >= 14'sd1) begin
      rsh = 7'd0;
      ef  = er_q[12:0] - 13'd1;
    end else begin
      rsh = (one_minus_er > 14'sd107) ? 7'd107 : one_minus_er[6:0];
      ef  = 13'd0;
    end
    t_sh      = p_q >> rsh;
    lost_mask = ~({106{1'b1}} << rsh);
    rm        = t_sh[105:53];
    rg        = t_sh[52];
    rst_bit   = (t_sh[51:0] != 52'd0) || ((p_q & lost_mask) != 106'd0);
    rinc      = rg && (rst_bit || rm[0]);
    mr        = {1'b0, rm} + {53'd0, rinc};
    mag66     = {1'b0, ef, 52'd0} + {12'd0, mr};
    if (mag66[65:52] >= {3'd0, fpie_pkg::FP_EXP_MAX}) begin
      rnd_bits = {sgn_q, fpie_pkg::FP_EXP_MAX, 52'd0};
    end else begin
      rnd_bits = {sgn_q, mag66[62:0]};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_bits_i;
      mag_q  <= mag_in;
      neg_q  <= in_neg;
      idx_q  <= 5'd31;
      if (in_bzero && (pw_u == 32'd0)) begin
        stat_q <= fpie_pkg::STAT_ZERO_ZERO;
        acc_q  <= 64'd0;
      end else if (in_bzero && in_neg) begin
        stat_q <= fpie_pkg::STAT_ZERO_NEG;
        acc_q  <= fpie_pkg::FP_ZERO_NEG;
      end else if (mag_in == 32'd0) begin
        stat_q <= fpie_pkg::STAT_NORMAL;
        acc_q  <= fpie_pkg::FP_ONE;
      end else begin
        stat_q <= fpie_pkg::STAT_NORMAL;
        acc_q  <= base_bits_i;
      end
    end
    if (cmd_i.idx_dec) begin
      idx_q <= idx_q - 5'd1;
    end
    // Multiply setup, or the whole product for special operands.
    if (cmd_i.mstart) begin
      if (mul_spec) begin
        acc_q <= spec_res;
      end
      ma_q   <= {a_exp != 11'd0, acc_q[51:0]};
      mb_q   <= {b_exp != 11'd0, opb[51:0]};
      er_q   <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 14'sd1022;
      sgn_q  <= acc_q[63] ^ opb[63];
      p_q    <= 106'd0;
      pcnt_q <= 3'd0;
    end
    if (cmd_i.pp_step) begin
      pp_q <= prod;
      if (pcnt_q != 3'd0) begin
        p_q <= p_q + pp_ext;
      end
      pcnt_q <= pcnt_q + 3'd1;
    end
    // Left shift until the leading one reaches the top.
    if (cmd_i.norm_step && !p_q[105] && (p_q != 106'd0)) begin
      p_q  <= {p_q[104:0], 1'b0};
      er_q <= er_q - 14'sd1;
    end
    if (cmd_i.round) begin
      acc_q <= rnd_bits;
    end
    // Reciprocal specials, or divisor setup.
    if (cmd_i.final_fix && neg_q) begin
      if (a_zero) begin
        acc_q <= {acc_q[63], fpie_pkg::FP_EXP_MAX, 52'd0};
      end else if (a_nan) begin
        acc_q <= acc_q | fpie_pkg::FP_QUIET_BIT;
      end else if (a_inf) begin
        acc_q <= {acc_q[63], 63'd0};
      end else begin
        d_q   <= {a_exp != 11'd0, acc_q[51:0]};
        de_q  <= $signed({3'd0, ea});
        sgn_q <= acc_q[63];
      end
    end
    if (cmd_i.dnorm_step) begin
      if (!d_q[52]) begin
        d_q  <= {d_q[51:0], 1'b0};
        de_q <= de_q - 14'sd1;
      end else begin
        rem_q  <= 55'd1 << 52;
        q_q    <= 56'd0;
        dcnt_q <= 6'd0;
        er_q   <= 14'sd2046 - de_q;
      end
    end
    // One restoring division step per cycle.
    if (cmd_i.div_step) begin
      if (rem_q >= {2'd0, d_q}) begin
        rem_q <= {rem_q[53:0] - {1'b0, d_q}, 1'b0};
        q_q   <= {q_q[54:0], 1'b1};
      end else begin
        rem_q <= {rem_q[53:0], 1'b0};
        q_q   <= {q_q[54:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 6'd1;
    end
    if (cmd_i.dpack) begin
      p_q <= {q_q, 50'd0} | {105'd0, rem_q != 55'd0};
    end
    if (cmd_i.out_load) begin
      res_q   <= acc_q;
      ostat_q <= stat_q;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o.trivial   = (stat_q != fpie_pkg::STAT_NORMAL) || (mag_q == 32'd0) || !rst_ni;
    sts_o.cur_bit   = mag_q[idx_q];
    sts_o.idx_zero  = (idx_q == 5'd0);
    sts_o.mul_spec  = mul_spec;
    sts_o.pp_done   = (pcnt_q == 3'd4);
    sts_o.norm_done = p_q[105] || (p_q == 106'd0);
    sts_o.need_div  = neg_q && !a_zero && !a_nan && !a_inf;
    sts_o.d_normed  = d_q[52];
    sts_o.div_last  = (dcnt_q == 6'd55);
  end

  assign result_bits_o = res_q;
  assign status_o      = ostat_q;

endmodule

`default_nettype wire

@@ rtl/core/fpie_ctrl.sv @@
// Sequencer of the integer power unit: walks the exponent bits, orders the
// squarings, multiplies and the reciprocal, and owns both handshakes. Depends on fpie_pkg.
`default_nettype none

module fpie_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output fpie_pkg::cmd_t  cmd_o,
  input  fpie_pkg::sts_t  sts_i
);

  fpie_pkg::state_e state_q, state_d;
  logic sq_q, sq_d;
  logic mulx_q, mulx_d;
  logic divm_q, divm_d;
  logic out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == fpie_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next-state and command decode.
  always_comb begin
    state_d     = state_q;
    sq_d        = sq_q;
    mulx_d      = mulx_q;
    divm_d      = divm_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.op_mulx = mulx_q;
    case (state_q)
      fpie_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          divm_d     = 1'b0;
          state_d    = fpie_pkg::ST_SCAN;
        end
      end
      fpie_pkg::ST_SCAN: begin
        if (sts_i.trivial) begin
          state_d = fpie_pkg::ST_DONE;
        end else if (sts_i.cur_bit) begin
          sq_d    = 1'b0;
          state_d = fpie_pkg::ST_NEXT;
        end else begin
          cmd_o.idx_dec = 1'b1;
        end
      end
      fpie_pkg::ST_NEXT: begin
        if (sq_q && sts_i.cur_bit) begin
          sq_d    = 1'b0;
          mulx_d  = 1'b1;
          state_d = fpie_pkg::ST_MSTART;
        end else if (sts_i.idx_zero) begin
          state_d = fpie_pkg::ST_FINAL;
        end else begin
          cmd_o.idx_dec = 1'b1;
          sq_d    = 1'b1;
          mulx_d  = 1'b0;
          state_d = fpie_pkg::ST_MSTART;
        end
      end
      fpie_pkg::ST_MSTART: begin
        cmd_o.mstart = 1'b1;
        state_d = sts_i.mul_spec ? fpie_pkg::ST_NEXT : fpie_pkg::ST_MPP;
      end
      fpie_pkg::ST_MPP: begin
        cmd_o.pp_step = 1'b1;
        if (sts_i.pp_done) begin
          state_d = fpie_pkg::ST_NORM;
        end
      end
      fpie_pkg::ST_NORM: begin
        cmd_o.norm_step = 1'b1;
        if (sts_i.norm_done) begin
          state_d = fpie_pkg::ST_ROUND;
        end
      end
      fpie_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d = divm_q ? fpie_pkg::ST_DONE : fpie_pkg::ST_NEXT;
      end
      fpie_pkg::ST_FINAL: begin
        cmd_o.final_fix = 1'b1;
        if (sts_i.need_div) begin
          divm_d  = 1'b1;
          state_d = fpie_pkg::ST_DNORM;
        end else begin
          state_d = fpie_pkg::ST_DONE;
        end
      end
      fpie_pkg::ST_DNORM: begin
        cmd_o.dnorm_step = 1'b1;
        if (sts_i.d_normed) begin
          state_d = fpie_pkg::ST_DIV;
        end
      end
      fpie_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = fpie_pkg::ST_DPACK;
        end
      end
      fpie_pkg::ST_DPACK: begin
        cmd_o.dpack = 1'b1;
        state_d = fpie_pkg::ST_NORM;
      end
      fpie_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = fpie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpie_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpie_pkg::ST_IDLE;
      sq_q        <= 1'b0;
      mulx_q      <= 1'b0;
      divm_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sq_q        <= sq_d;
      mulx_q      <= mulx_d;
      divm_q      <= divm_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A new result appears only when an item finishes.
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == fpie_pkg::ST_DONE))
    else $error("result raised outside completion");

  // A finished result is never loaded over one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

  // The divider runs only for a negative exponent.
  a_div_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpie_pkg::ST_DIV) |-> divm_q)
    else $error("divider active without reciprocal");

  // Rounding always follows normalization.
  a_round_after_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fpie_pkg::ST_ROUND) |-> $past(state_q == fpie_pkg::ST_NORM))
    else $error("round without normalization");
`endif

endmodule

`default_nettype wire

@@ rtl/core/float_power_integer_exponent_unit.sv @@
// Flow: a zero base with a zero or negative exponent, or a zero exponent, goes straight to the result;
// otherwise the exponent bits are scanned from the top, then each rounded product runs through its
// partial products, the normalizing shifts (more of them for subnormal operands) and rounding, and for
// a negative exponent the reciprocal follows (divisor normalization, bit-serial divider, rounding).
// Handshake: a new item is taken only when idle; a result still waiting holds the next one.
// Reset: rst_ni asynchronous, active low, clears the sequencer and the output valid.
// Top level of the integer power unit; depends on fpie_pkg, fpie_ctrl and fpie_dp.
`default_nettype none

module float_power_integer_exponent_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [63:0]       base_bits_i,
  input  wire signed [31:0] power_value_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [63:0]       result_bits_o,
  output logic [1:0]        status_o
);

  fpie_pkg::cmd_t cmd;
  fpie_pkg::sts_t sts;

  // Sequencer.
  fpie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Arithmetic datapath with the output register.
  fpie_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .base_bits_i   (base_bits_i),
    .power_value_i (power_value_i),
    .result_bits_o (result_bits_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire
